/* hw/rtl/macdf_pkg.sv */
// Shared types, constants and helpers for the MACD indicator filter.
package macdf_pkg;

    // Value format: signed fixed point on the price's binary point
    localparam int VAL_W           = 40;
    localparam int PERIOD_W        = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int PRICE_WIDTH_DEF = 32;

    // Numerator avg*(n-1) + 2x needs 40 + 9 bits plus one for the add
    localparam int NUM_W      = VAL_W + PERIOD_W + 2;
    localparam int DIVISOR_W  = PERIOD_W + 1;
    // Quotient magnitude never exceeds 2^(VAL_W-1), so VAL_W quotient bits do
    localparam int QUO_W      = VAL_W;
    // Partial remainder stays below the divisor (at most 256)
    localparam int REM_W      = PERIOD_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_CYCLES = QUO_W / DIV_STEP;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    // Period reset values
    localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST  = 8'd12;
    localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST   = 8'd26;
    localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;

    typedef logic signed [VAL_W-1:0]   val_t;
    typedef logic signed [VAL_W+1:0]   wide_t;

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_PERIOD  = 2'd0,
        CFG_LONG_PERIOD   = 2'd1,
        CFG_SIGNAL_PERIOD = 2'd2
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_WB,
        ST_DIFF,
        ST_OUT
    } state_t;

    // Which average the shared unit is working on
    typedef enum logic [1:0] {
        SEL_FAST,
        SEL_SLOW,
        SEL_SIG
    } sel_t;

    // Clamp a wide signed value to the signed VAL_W range
    function automatic val_t sat_val(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = {3'b000, {(VAL_W-1){1'b1}}};
        lo = {3'b111, {(VAL_W-1){1'b0}}};
        if (v > hi) begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/macd_indicator_filter_top.sv */
// MACD oscillator: fast/slow/signal exponential averages over one shared divider.
// Usage
//  s_ channel: one closing price per transfer (unsigned fixed point) plus a
//  series start flag. A start price loads both averages, clears the signal
//  average and produces no result; s_ready stays high for the next price.
//  m_ channel: one result per non-start price: difference line, signal line
//  and histogram, 40-bit signed on the price's binary point.
//  cfg_ channel: period registers (short, long, signal), always ready; write
//  only while no price is in flight. A period of zero behaves as one.
// Sequence
//  A non-start price runs through three average updates (fast, slow,
//  signal), each a multiply, a sign fold, divider cycles that each retire
//  four quotient bits, and a write back; the difference is taken between
//  the slow and signal updates, and the output register is loaded last.
//  The shared radix-2 divider serves all three updates; one price is in
//  work at a time, so the next price is taken only after its result is loaded.
// Reset and stall
//  aresetn (synchronous, active low) restores the default periods and zeroes
//  the averages. A result waits in the output register while m_ready is low;
//  the next price is accepted meanwhile and held back only at its own output.
module macd_indicator_filter_top #(
    parameter int PRICE_WIDTH = macdf_pkg::PRICE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [PRICE_WIDTH-1:0]               s_close_price,
    input  logic                                 s_series_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [macdf_pkg::VAL_W-1:0]   m_diff_line,
    output logic signed [macdf_pkg::VAL_W-1:0]   m_signal_line,
    output logic signed [macdf_pkg::VAL_W-1:0]   m_histogram,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [macdf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [macdf_pkg::PERIOD_W-1:0]       cfg_data
);
    import macdf_pkg::*;

    // Control state
    state_t state_reg, state_next;
    sel_t   sel_reg, sel_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;

    // Period registers
    logic [PERIOD_W-1:0] short_reg, long_reg, signal_reg;

    // Averages
    val_t fast_reg, slow_reg, sig_reg;

    // Datapath payload
    val_t                    price_reg, dif_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic                    neg_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [REM_W-1:0]        rem_reg;
    val_t                    diff_out_reg, sig_out_reg, hist_out_reg;

    // Combinational datapath
    val_t                      avg_op, x_op, price_in, ema_res, dif_calc, hist_calc;
    logic [PERIOD_W-1:0]       period_op, n_eff, nm1;
    logic [DIVISOR_W-1:0]      divisor;
    logic signed [VAL_W+PERIOD_W:0] prod;
    logic signed [NUM_W-1:0]   num_calc;
    logic [NUM_W-1:0]          mag;
    logic [QUO_W-1:0]          quo_step;
    logic [REM_W-1:0]          rem_step;
    wide_t                     q_wide, hist_diff;
    logic                      s_xfer, load_out;

    // Operand selection for the shared unit
    always_comb begin
        unique case (sel_reg)
            SEL_FAST: begin
                avg_op    = fast_reg;
                x_op      = price_reg;
                period_op = short_reg;
            end
            SEL_SLOW: begin
                avg_op    = slow_reg;
                x_op      = price_reg;
                period_op = long_reg;
            end
            SEL_SIG: begin
                avg_op    = sig_reg;
                x_op      = dif_reg;
                period_op = signal_reg;
            end
            default: begin
                avg_op    = fast_reg;
                x_op      = price_reg;
                period_op = short_reg;
            end
        endcase
    end

    // Effective period, multiplier and divisor
    assign n_eff    = (period_op == '0) ? PERIOD_W'(1) : period_op;
    assign nm1      = n_eff - PERIOD_W'(1);
    assign divisor  = {1'b0, n_eff} + DIVISOR_W'(1);
    assign prod     = avg_op * $signed({1'b0, nm1});
    assign num_calc = NUM_W'(prod) + NUM_W'(x_op) + NUM_W'(x_op);

    // Magnitude of the numerator for the unsigned divider
    assign mag = num_reg[NUM_W-1] ? (~num_reg + NUM_W'(1)) : num_reg;

    // Four restoring division steps per cycle on the narrow remainder
    always_comb begin
        logic [REM_W-1:0]     r;
        logic [QUO_W-1:0]     q;
        logic [DIVISOR_W-1:0] trial;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial = {r, q[QUO_W-1]};
            q     = {q[QUO_W-2:0], 1'b0};
            if (trial >= divisor) begin
                r    = REM_W'(trial - divisor);
                q[0] = 1'b1;
            end else begin
                r = trial[REM_W-1:0];
            end
        end
        rem_step = r;
        quo_step = q;
    end

    // Signed quotient (truncated toward zero) and the other results
    assign q_wide    = wide_t'({1'b0, quo_reg});
    assign ema_res   = sat_val(neg_reg ? -q_wide : q_wide);
    assign dif_calc  = sat_val(wide_t'(fast_reg) - wide_t'(slow_reg));
    assign hist_diff = wide_t'(dif_reg) - wide_t'(sig_reg);
    assign hist_calc = sat_val(hist_diff + hist_diff);
    assign price_in  = sat_val($signed({{(VAL_W+2-PRICE_WIDTH){1'b0}}, s_close_price}));

    // Next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && !s_series_start) begin
                    state_next = ST_MUL;
                    sel_next   = SEL_FAST;
                end
            end
            ST_MUL:  state_next = ST_PREP;
            ST_PREP: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                unique case (sel_reg)
                    SEL_FAST: begin
                        state_next = ST_MUL;
                        sel_next   = SEL_SLOW;
                    end
                    SEL_SLOW: begin
                        state_next = ST_DIFF;
                        sel_next   = SEL_SIG;
                    end
                    default:  state_next = ST_OUT;
                endcase
            end
            ST_DIFF: state_next = ST_MUL;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        load_out  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    assign s_xfer        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_diff_line   = diff_out_reg;
    assign m_signal_line = sig_out_reg;
    assign m_histogram   = hist_out_reg;

    // Control registers, periods and averages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sel_reg     <= SEL_FAST;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            short_reg   <= SHORT_PERIOD_RST;
            long_reg    <= LONG_PERIOD_RST;
            signal_reg  <= SIGNAL_PERIOD_RST;
            fast_reg    <= '0;
            slow_reg    <= '0;
            sig_reg     <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;

            // Divider cycle count
            if (state_reg == ST_PREP) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_DIV) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            // Output valid
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Period writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_SHORT_PERIOD:  short_reg  <= cfg_data;
                    CFG_LONG_PERIOD:   long_reg   <= cfg_data;
                    CFG_SIGNAL_PERIOD: signal_reg <= cfg_data;
                    default: ;
                endcase
            end

            // Series start loads the averages; write back updates one
            if (s_xfer && s_series_start) begin
                fast_reg <= price_in;
                slow_reg <= price_in;
                sig_reg  <= '0;
            end else if (state_reg == ST_WB) begin
                unique case (sel_reg)
                    SEL_FAST: fast_reg <= ema_res;
                    SEL_SLOW: slow_reg <= ema_res;
                    SEL_SIG:  sig_reg  <= ema_res;
                    default: ;
                endcase
            end
        end
    end

    // Datapath payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            price_reg <= price_in;
        end
        if (state_reg == ST_MUL) begin
            num_reg <= num_calc;
        end
        if (state_reg == ST_PREP) begin
            neg_reg <= num_reg[NUM_W-1];
            rem_reg <= mag[QUO_W+REM_W-1:QUO_W];
            quo_reg <= mag[QUO_W-1:0];
        end else if (state_reg == ST_DIV) begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
        if (state_reg == ST_DIFF) begin
            dif_reg <= dif_calc;
        end
        if (load_out) begin
            diff_out_reg <= dif_reg;
            sig_out_reg  <= sig_reg;
            hist_out_reg <= hist_calc;
        end
    end

    // Assertions
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < divisor))
        else $error("divider remainder not below divisor");

    a_numerator_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |->
            ((mag[NUM_W-1:QUO_W+REM_W] == '0) &&
             ({1'b0, mag[QUO_W+REM_W-1:QUO_W]} < divisor)))
        else $error("numerator too large for the quotient width");

    a_quotient_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |->
            ((quo_reg[QUO_W-1] == 1'b0) || (quo_reg[QUO_W-2:0] == '0)))
        else $error("quotient magnitude exceeds value range");

    a_start_clears_signal: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_series_start) |=> ((sig_reg == '0) && (state_reg == ST_IDLE)))
        else $error("series start did not clear the signal average");

endmodule
